// File: src/skt_pkg.sv
// Shared constants, action and status codes and channel structs of the sorted key table.
`timescale 1ns / 1ps
package skt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 128;

  localparam logic [2:0] ACT_INSERT     = 3'd0;
  localparam logic [2:0] ACT_LOOKUP     = 3'd1;
  localparam logic [2:0] ACT_REMOVE_KEY = 3'd2;
  localparam logic [2:0] ACT_REMOVE_IDX = 3'd3;
  localparam logic [2:0] ACT_READ_IDX   = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic [7:0]  entry_index;
  } skt_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             already_present;
    logic [7:0]       result_index;
    logic [63:0]      key_high;
    logic [63:0]      key_low;
    logic [CNT_W-1:0] entry_count;
  } skt_res_t;

endpackage

// File: src/skt_engine.sv
// Sequencer and key memory: binary search, shift up and shift down over one RAM.
`timescale 1ns / 1ps
module skt_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  skt_pkg::skt_req_t req,
  output logic              req_ready,
  output logic              res_valid,
  output skt_pkg::skt_res_t res,
  input  logic              res_ready
);
  import skt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_EQ,
    S_SHIFT,
    S_READ,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  skt_req_t          req_r, req_nxt;
  skt_res_t          res_r, res_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [CNT_W-1:0]  mid_r, mid_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  src_r, src_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              up_r, up_nxt;
  logic              ins_r, ins_nxt;
  logic              chk_r, chk_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;

  logic [KEY_W-1:0]  mem [TABLE_DEPTH];
  logic [KEY_W-1:0]  rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [KEY_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [KEY_W-1:0]  key;
  logic [CNT_W-1:0]  mid;
  logic              key_less;
  logic              key_eq;
  logic              found;

  assign key      = {req_r.key_high, req_r.key_low};
  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign key_less = rd_data_r < key;
  assign key_eq   = rd_data_r == key;
  assign found    = chk_r && key_eq;

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res             = res_r;
    res.entry_count = count_r;
  end

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    res_nxt     = res_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    pos_nxt     = pos_r;
    src_nxt     = src_r;
    n_nxt       = n_r;
    up_nxt      = up_r;
    ins_nxt     = ins_r;
    chk_nxt     = chk_r;
    wr_pend_nxt = wr_pend_r;
    wr_addr_nxt = wr_addr_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_r;
    mem_wdata   = rd_data_r;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt = req;
          res_nxt = '0;
          lo_nxt  = '0;
          hi_nxt  = count_r;
          case (req.action)
            ACT_INSERT, ACT_LOOKUP, ACT_REMOVE_KEY: begin
              state_nxt = S_SRCH;
            end
            ACT_REMOVE_IDX, ACT_READ_IDX: begin
              if ({1'b0, req.entry_index} >= count_r) begin
                res_nxt.status = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                res_nxt.result_index = req.entry_index;
                pos_nxt              = {1'b0, req.entry_index};
                if (req.action == ACT_REMOVE_IDX) begin
                  src_nxt   = {1'b0, req.entry_index} + 1'b1;
                  n_nxt     = count_r - {1'b0, req.entry_index} - 1'b1;
                  up_nxt    = 1'b0;
                  ins_nxt   = 1'b0;
                  state_nxt = S_SHIFT;
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = req.entry_index;
                  state_nxt = S_READ;
                end
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          mem_re    = 1'b1;
          mem_raddr = mid[ADDR_W-1:0];
          state_nxt = S_CMP;
        end else begin
          // The search has settled; fetch that entry to test for an exact match.
          pos_nxt   = lo_r;
          chk_nxt   = lo_r < count_r;
          mem_re    = lo_r < count_r;
          mem_raddr = lo_r[ADDR_W-1:0];
          state_nxt = S_EQ;
        end
      end
      S_CMP: begin
        if (key_less) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end
      S_EQ: begin
        case (req_r.action)
          ACT_INSERT: begin
            if (found) begin
              res_nxt.already_present = 1'b1;
              res_nxt.result_index    = pos_r[ADDR_W-1:0];
              state_nxt               = S_DONE;
            end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
              res_nxt.status = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              res_nxt.result_index = pos_r[ADDR_W-1:0];
              src_nxt              = count_r - 1'b1;
              n_nxt                = count_r - pos_r;
              up_nxt               = 1'b1;
              ins_nxt              = 1'b1;
              state_nxt            = S_SHIFT;
            end
          end
          ACT_LOOKUP: begin
            if (found) begin
              res_nxt.result_index = pos_r[ADDR_W-1:0];
            end else begin
              res_nxt.status = ST_MISSING;
            end
            state_nxt = S_DONE;
          end
          default: begin
            if (found) begin
              res_nxt.result_index = pos_r[ADDR_W-1:0];
              src_nxt              = pos_r + 1'b1;
              n_nxt                = count_r - pos_r - 1'b1;
              up_nxt               = 1'b0;
              ins_nxt              = 1'b0;
              state_nxt            = S_SHIFT;
            end else begin
              res_nxt.status = ST_MISSING;
              state_nxt      = S_DONE;
            end
          end
        endcase
      end
      S_SHIFT: begin
        // Each cycle reads one entry and writes the one read in the cycle before.
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = rd_data_r;
        end
        wr_pend_nxt = 1'b0;
        if (n_r != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = src_r[ADDR_W-1:0];
          wr_pend_nxt = 1'b1;
          if (up_r) begin
            wr_addr_nxt = src_r[ADDR_W-1:0] + 1'b1;
            src_nxt     = src_r - 1'b1;
          end else begin
            wr_addr_nxt = src_r[ADDR_W-1:0] - 1'b1;
            src_nxt     = src_r + 1'b1;
          end
          n_nxt = n_r - 1'b1;
        end else if (!wr_pend_r) begin
          if (ins_r) begin
            mem_we    = 1'b1;
            mem_waddr = pos_r[ADDR_W-1:0];
            mem_wdata = key;
            count_nxt = count_r + 1'b1;
          end else begin
            count_nxt = count_r - 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        res_nxt.key_high = rd_data_r[KEY_W-1:64];
        res_nxt.key_low  = rd_data_r[63:0];
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    pos_r     <= pos_nxt;
    src_r     <= src_nxt;
    n_r       <= n_nxt;
    up_r      <= up_nxt;
    ins_r     <= ins_nxt;
    chk_r     <= chk_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !mem_we)
    else $error("memory written outside a shift");

  a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> state_r == S_SHIFT)
    else $error("pending shift write outside the shift state");

  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (mid_r >= lo_r && mid_r < hi_r))
    else $error("search probe outside its window");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_FULL) |-> count_r == CNT_W'(TABLE_DEPTH))
    else $error("table full reported with room left");
`endif

endmodule

// File: src/sorted_key_table_top.sv
// Top level of the sorted key table: input handshake, engine and output register.
`timescale 1ns / 1ps
// Sorted table of up to 256 keys of 128 bits, kept in ascending unsigned order.
// Input channel in_*: one beat carries an action (insert, lookup, remove by key,
// remove by index, read by index), a key and an index. Output channel out_*:
// exactly one result beat per input beat, in order, carrying status, position,
// the key read and the entry count after the action.
// Lookup and the search part of insert or remove step through the probes of the
// binary search (S_SRCH, S_CMP). Insert and remove then move up to the entry count
// of entries, one entry a cycle, because the key memory has one read and one write
// port. The engine works on one beat at a time and takes no new input beat until
// it is through with the last.
// A new input beat is taken as soon as the engine has handed its result to the
// output register, even while that result still waits for out_ready.
// When the receiver stalls, the engine holds its finished result until the
// output register frees, and in_ready stays low meanwhile.
// Reset empties the table at once (entry count zero); no clearing pass is run.
module sorted_key_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_key_high,
  input  logic [63:0] in_key_low,
  input  logic [7:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_already_present,
  output logic [7:0]  out_result_index,
  output logic [63:0] out_key_high,
  output logic [63:0] out_key_low,
  output logic [8:0]  out_entry_count
);
  import skt_pkg::*;

  skt_req_t req;
  skt_res_t res;
  skt_res_t out_r;
  logic     out_valid_r;
  logic     res_valid;
  logic     res_take;

  assign req.action      = in_action;
  assign req.key_high    = in_key_high;
  assign req.key_low     = in_key_low;
  assign req.entry_index = in_entry_index;

  // The output register frees when empty or when its beat leaves this cycle.
  assign res_take = res_valid && (!out_valid_r || out_ready);

  skt_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (in_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_take)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_already_present = out_r.already_present;
  assign out_result_index    = out_r.result_index;
  assign out_key_high        = out_r.key_high;
  assign out_key_low         = out_r.key_low;
  assign out_entry_count     = out_r.entry_count;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the sorted key table: planned stimulus, shadow table, result checker.
`timescale 1ns / 1ps
module tb_top;
  import skt_pkg::*;

  // Two copies of the shadow table: one steers the stimulus while it is
  // planned, the other predicts each beat as the block accepts it.
  localparam int PLAN_VIEW   = 0;
  localparam int CHECK_VIEW  = 1;
  localparam int RANDOM_BEATS = 925;
  localparam int DRAIN_CYCLES = 600;
  localparam int PRINT_LIMIT  = 100;
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_action = '0;
  logic [63:0] in_key_high = '0;
  logic [63:0] in_key_low = '0;
  logic [7:0] in_entry_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic out_already_present;
  logic [7:0] out_result_index;
  logic [63:0] out_key_high;
  logic [63:0] out_key_low;
  logic [8:0] out_entry_count;

  logic [KEY_W-1:0] shadow_keys [2][TABLE_DEPTH];
  int unsigned shadow_fill [2] = '{0, 0};

  skt_req_t pending_beats [$];
  skt_res_t expected_answers [$];

  logic beat_taken = 1'b0;
  int error_count = 0;
  int results_checked = 0;
  int beats_by_action [8] = '{default: 0};
  int status_seen [4] = '{default: 0};
  int present_seen = 0;
  int peak_fill = 0;

  sorted_key_table_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_key_high(in_key_high), .in_key_low(in_key_low), .in_entry_index(in_entry_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_already_present(out_already_present), .out_result_index(out_result_index),
    .out_key_high(out_key_high), .out_key_low(out_key_low),
    .out_entry_count(out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one action to a shadow table and returns the result it should give.
  function automatic skt_res_t table_action(input int view, input skt_req_t req);
    skt_res_t res;
    logic [KEY_W-1:0] key;
    int unsigned lo, hi, mid, pos, fill, idx;
    logic found;
    int i;
    res = '0;
    key = {req.key_high, req.key_low};
    fill = shadow_fill[view];
    idx = req.entry_index;
    lo = 0;
    hi = fill;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (shadow_keys[view][mid] < key) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    found = (pos < fill) && (shadow_keys[view][pos] == key);
    case (req.action)
      ACT_INSERT: begin
        if (found) begin
          res.already_present = 1'b1;
          res.result_index = pos[7:0];
        end else if (fill >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = fill; i > int'(pos); i--) shadow_keys[view][i] = shadow_keys[view][i-1];
          shadow_keys[view][pos] = key;
          fill++;
          res.result_index = pos[7:0];
        end
      end
      ACT_LOOKUP, ACT_REMOVE_KEY: begin
        if (!found) begin
          res.status = ST_MISSING;
        end else begin
          res.result_index = pos[7:0];
          if (req.action == ACT_REMOVE_KEY) begin
            for (i = pos; i < int'(fill) - 1; i++) shadow_keys[view][i] = shadow_keys[view][i+1];
            fill--;
          end
        end
      end
      ACT_REMOVE_IDX, ACT_READ_IDX: begin
        if (idx >= fill) begin
          res.status = ST_RANGE;
        end else begin
          res.result_index = idx[7:0];
          if (req.action == ACT_REMOVE_IDX) begin
            for (i = idx; i < int'(fill) - 1; i++) shadow_keys[view][i] = shadow_keys[view][i+1];
            fill--;
          end else begin
            res.key_high = shadow_keys[view][idx][127:64];
            res.key_low = shadow_keys[view][idx][63:0];
          end
        end
      end
      default: ;
    endcase
    shadow_fill[view] = fill;
    res.entry_count = fill[CNT_W-1:0];
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    logic [KEY_W-1:0] key;
    key = {$urandom, $urandom, $urandom, $urandom};
    if (shadow_fill[PLAN_VIEW] != 0)
      key = shadow_keys[PLAN_VIEW][$urandom_range(0, shadow_fill[PLAN_VIEW] - 1)];
    return key;
  endfunction

  // Mostly fresh keys, with many sharing a high half so that the low half decides.
  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] hi_half, lo_half;
    logic [63:0] corner;
    hi_half = {$urandom, $urandom};
    lo_half = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: corner = '0;
      1: corner = '1;
      2: corner = 64'h8000_0000_0000_0000;
      default: corner = 64'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 3))
      0: return {hi_half, lo_half};
      1: return {corner, lo_half};
      2: return {hi_half, corner};
      default: return stored_key() + KEY_W'($urandom_range(1, 3)) - KEY_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [7:0] pick_index();
    int unsigned fill;
    fill = shadow_fill[PLAN_VIEW];
    if (fill == 0 || $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0 && fill < TABLE_DEPTH) return fill[7:0];
    return 8'($urandom_range(0, fill - 1));
  endfunction

  task automatic plan_beat(input logic [2:0] act, input logic [KEY_W-1:0] key,
                           input logic [7:0] idx);
    skt_req_t req;
    req.action = act;
    req.key_high = key[127:64];
    req.key_low = key[63:0];
    req.entry_index = idx;
    pending_beats.push_back(req);
    void'(table_action(PLAN_VIEW, req));
  endtask

  task automatic report_error(input string msg);
    error_count++;
    // A badly broken block would otherwise flood the log.
    if (error_count <= PRINT_LIMIT) $display("%0t ns: ERROR %s", $time, msg);
  endtask

  // Sender: bursts of beats separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin : drive_beats
    skt_req_t nxt;
    logic next_valid;
    if (rst_n) begin
      next_valid = in_valid && !beat_taken;
      beat_taken = 1'b0;
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_beats.size() != 0) begin
          nxt = pending_beats.pop_front();
          in_action <= nxt.action;
          in_key_high <= nxt.key_high;
          in_key_low <= nxt.key_low;
          in_entry_index <= nxt.entry_index;
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: cycles through steady, random, long-stall and sparse phases.
  int ready_phase = 0;
  int stall_left = 0;
  always @(negedge clk) begin : pace_receiver
    logic next_ready;
    if (rst_n) begin
      ready_phase++;
      case (ready_phase[10:9])
        2'd0: next_ready = 1'b1;
        2'd1: next_ready = $urandom_range(0, 3) != 0;
        2'd2: begin
          if (stall_left != 0) stall_left--;
          else if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 24);
          next_ready = stall_left == 0;
        end
        default: next_ready = ready_phase[2:0] == 3'd5;
      endcase
      out_ready <= next_ready;
    end
  end

  // Checks each result beat, then predicts any input beat taken at this edge.
  always @(posedge clk) begin : check_beats
    skt_res_t got, want;
    skt_req_t req;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.status = out_status;
        got.already_present = out_already_present;
        got.result_index = out_result_index;
        got.key_high = out_key_high;
        got.key_low = out_key_low;
        got.entry_count = out_entry_count;
        if (expected_answers.size() == 0) begin
          report_error($sformatf("result beat with nothing outstanding: %p", got));
        end else begin
          want = expected_answers.pop_front();
          results_checked++;
          if (got.status !== want.status)
            report_error($sformatf("result %0d status %0d, want %0d",
                                   results_checked, got.status, want.status));
          if (got.already_present !== want.already_present)
            report_error($sformatf("result %0d already_present %b, want %b",
                                   results_checked, got.already_present, want.already_present));
          if (got.result_index !== want.result_index)
            report_error($sformatf("result %0d result_index %0d, want %0d",
                                   results_checked, got.result_index, want.result_index));
          if (got.key_high !== want.key_high)
            report_error($sformatf("result %0d key_high %h, want %h",
                                   results_checked, got.key_high, want.key_high));
          if (got.key_low !== want.key_low)
            report_error($sformatf("result %0d key_low %h, want %h",
                                   results_checked, got.key_low, want.key_low));
          if (got.entry_count !== want.entry_count)
            report_error($sformatf("result %0d entry_count %0d, want %0d",
                                   results_checked, got.entry_count, want.entry_count));
          status_seen[want.status]++;
          if (want.already_present) present_seen++;
          if (int'(want.entry_count) > peak_fill) peak_fill = want.entry_count;
        end
      end
      if (in_valid && in_ready) begin
        req.action = in_action;
        req.key_high = in_key_high;
        req.key_low = in_key_low;
        req.entry_index = in_entry_index;
        beats_by_action[req.action]++;
        expected_answers.push_back(table_action(CHECK_VIEW, req));
        beat_taken = 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic grow;
    int full_beats;
    int roll;
    int n;

    // Empty table: every search misses and every index is out of range.
    plan_beat(ACT_READ_IDX, '0, 8'd0);
    plan_beat(ACT_REMOVE_IDX, '1, 8'hFF);
    plan_beat(ACT_LOOKUP, '1, 8'd0);
    plan_beat(ACT_REMOVE_KEY, '0, 8'd0);
    // Extreme keys and keys that differ only across the half boundary, then lookups, reads, unused actions and removes.
    plan_beat(ACT_INSERT, '1, 8'd0);
    plan_beat(ACT_INSERT, '0, 8'hFF);
    plan_beat(ACT_INSERT, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd0);
    plan_beat(ACT_INSERT, {64'h1, 64'h0}, 8'd0);
    plan_beat(ACT_INSERT, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, 8'd0);
    plan_beat(ACT_INSERT, '0, 8'd0);
    plan_beat(ACT_INSERT, {64'h8000_0000_0000_0000, 64'h1}, 8'd0);
    plan_beat(ACT_LOOKUP, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd0);
    plan_beat(ACT_LOOKUP, {64'h1, 64'h1}, 8'd0);
    plan_beat(ACT_READ_IDX, '1, 8'd0);
    plan_beat(ACT_READ_IDX, '0, 8'd5);
    plan_beat(ACT_READ_IDX, '0, 8'd6);
    plan_beat(ACT_READ_IDX, '0, 8'hFF);
    plan_beat(ACT_UNUSED_FIRST, '1, 8'hFF);
    plan_beat(ACT_UNUSED_FIRST + 3'd1, {64'h0, 64'h1}, 8'd0);
    plan_beat(ACT_UNUSED_LAST, '1, 8'hFF);
    plan_beat(ACT_REMOVE_KEY, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 8'd0);
    plan_beat(ACT_REMOVE_IDX, '0, 8'd0);
    plan_beat(ACT_REMOVE_IDX, '0, 8'(shadow_fill[PLAN_VIEW] - 1));
    plan_beat(ACT_REMOVE_KEY, '0, 8'd0);
    plan_beat(ACT_LOOKUP, '1, 8'd0);

    // Random part: fill the table up to full, dwell there, then drain it, and repeat.
    grow = 1'b1;
    full_beats = 0;
    for (n = 0; n < RANDOM_BEATS; n++) begin
      roll = $urandom_range(0, 99);
      if (grow) begin
        if (roll < 60) plan_beat(ACT_INSERT, random_key(), pick_index());
        else if (roll < 72) plan_beat(ACT_INSERT, stored_key(), pick_index());
        else if (roll < 80) plan_beat(ACT_LOOKUP, stored_key(), pick_index());
        else if (roll < 85) plan_beat(ACT_LOOKUP, random_key(), pick_index());
        else if (roll < 90) plan_beat(ACT_READ_IDX, random_key(), pick_index());
        else if (roll < 94) plan_beat(ACT_REMOVE_KEY, stored_key(), pick_index());
        else if (roll < 97) plan_beat(ACT_REMOVE_IDX, random_key(), pick_index());
        else plan_beat(3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
                       random_key(), pick_index());
      end else begin
        if (roll < 38) plan_beat(ACT_REMOVE_KEY, stored_key(), pick_index());
        else if (roll < 43) plan_beat(ACT_REMOVE_KEY, random_key(), pick_index());
        else if (roll < 68) plan_beat(ACT_REMOVE_IDX, random_key(), pick_index());
        else if (roll < 78) plan_beat(ACT_LOOKUP, stored_key(), pick_index());
        else if (roll < 88) plan_beat(ACT_READ_IDX, random_key(), pick_index());
        else if (roll < 96) plan_beat(ACT_INSERT, random_key(), pick_index());
        else plan_beat(3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST)),
                       random_key(), pick_index());
      end
      if (grow && shadow_fill[PLAN_VIEW] == TABLE_DEPTH) full_beats++;
      if (full_beats >= 16) begin
        grow = 1'b0;
        full_beats = 0;
      end
      if (!grow && shadow_fill[PLAN_VIEW] == 0) grow = 1'b1;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_answers.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_answers.size()));

    $display("Checked %0d results: %0d inserts, %0d lookups, %0d removes by key, %0d by index,",
             results_checked, beats_by_action[ACT_INSERT], beats_by_action[ACT_LOOKUP],
             beats_by_action[ACT_REMOVE_KEY], beats_by_action[ACT_REMOVE_IDX]);
    $display("%0d reads; %0d duplicates, %0d full, %0d misses, %0d out of range; peak %0d keys.",
             beats_by_action[ACT_READ_IDX], present_seen, status_seen[ST_FULL],
             status_seen[ST_MISSING], status_seen[ST_RANGE], peak_fill);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d beats unsent and %0d results outstanding",
             pending_beats.size(), expected_answers.size());
    $display("Verification failed");
    $finish;
  end

endmodule
